[rtl/core/u7e_pkg.sv]
// Shared types and constants for the UTF-7 stream encoder.
// Holds item structs, the packet passed from front to back, and the base64 digit map.
package u7e_pkg;

  // Input item opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Fixed characters of the encoding
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [15:0] CP_PLUS = 16'h002B;

  // Most bytes one item can cause, and the width of a byte count
  localparam int MAX_BYTES = 5;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic        opcode;
    logic [15:0] code_point;
    logic [7:0]  attribute;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic [7:0] out_attribute;
    logic       forced;
    logic       last;
  } out_item_t;

  // One byte as the front builds it
  typedef struct packed {
    logic [6:0] ch;
    logic [7:0] attr;
    logic       forced;
  } enc_byte_t;

  // All bytes caused by one item, oldest in slot 0
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    enc_byte_t [MAX_BYTES-1:0]       bytes;
  } packet_t;

  // Map a 6-bit value to its base64 character
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    r = 7'h2F;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CH_PLUS;
    end
    return r;
  endfunction

endpackage

[rtl/core/u7e_front.sv]
// Front end: accepts items, tracks run state and builds the byte packet for each item.
// Depends on u7e_pkg.
module u7e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u7e_pkg::in_item_t  in_data,
  output logic               full,
  output logic               q_push,
  output u7e_pkg::packet_t   q_data,
  input  logic               q_full
);

  localparam logic [1:0] MODE_DIRECT    = 2'd0;
  localparam logic [1:0] MODE_RUN_EMPTY = 2'd1;
  localparam logic [1:0] MODE_RUN_PEND4 = 2'd2;
  localparam logic [1:0] MODE_RUN_PEND2 = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic [5:0] left_r, left_nxt;
  logic [7:0] prev_r, prev_nxt;

  logic                   accept;
  logic                   close;
  logic                   is_ascii;
  logic [1:0]             mode_eff;
  logic [5:0]             merged;
  logic [u7e_pkg::CNT_W-1:0] n;
  u7e_pkg::packet_t       pkt;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Build the packet and next run state for the item at the port
  always_comb begin
    pkt      = '0;
    n        = '0;
    merged   = '0;
    mode_nxt = mode_r;
    left_nxt = left_r;
    prev_nxt = in_data.attribute;
    is_ascii = (in_data.code_point[15:7] == 9'd0);
    close    = (mode_r != MODE_DIRECT) &&
               ((in_data.opcode == u7e_pkg::OP_END) ||
                (in_data.attribute != prev_r) || is_ascii);

    // close the open run with its own attribute
    if (close) begin
      if (mode_r != MODE_RUN_EMPTY) begin
        pkt.bytes[n] = '{ch: u7e_pkg::b64_char(left_r), attr: prev_r, forced: 1'b1};
        n = n + 1'b1;
      end
      pkt.bytes[n] = '{ch: u7e_pkg::CH_MINUS, attr: prev_r, forced: 1'b1};
      n = n + 1'b1;
    end
    mode_eff = close ? MODE_DIRECT : mode_r;

    if (in_data.opcode == u7e_pkg::OP_END) begin
      prev_nxt = '0;
      mode_nxt = MODE_DIRECT;
    end else if (is_ascii) begin
      mode_nxt = MODE_DIRECT;
      if (in_data.code_point == u7e_pkg::CP_PLUS) begin
        pkt.bytes[n] = '{ch: u7e_pkg::CH_PLUS, attr: in_data.attribute, forced: 1'b1};
        n = n + 1'b1;
        pkt.bytes[n] = '{ch: u7e_pkg::CH_MINUS, attr: in_data.attribute, forced: 1'b1};
        n = n + 1'b1;
      end else begin
        pkt.bytes[n] = '{ch: in_data.code_point[6:0], attr: in_data.attribute,
                         forced: 1'b0};
        n = n + 1'b1;
      end
    end else begin
      // open a run when none is open
      if (mode_eff == MODE_DIRECT) begin
        pkt.bytes[n] = '{ch: u7e_pkg::CH_PLUS, attr: in_data.attribute, forced: 1'b0};
        n = n + 1'b1;
      end
      case (mode_eff)
        MODE_DIRECT, MODE_RUN_EMPTY: begin
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[15:10]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[9:4]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          left_nxt = {in_data.code_point[3:0], 2'b00};
          mode_nxt = MODE_RUN_PEND4;
        end
        MODE_RUN_PEND4: begin
          merged = left_r | {4'b0000, in_data.code_point[15:14]};
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(merged),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[13:8]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[7:2]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          left_nxt = {in_data.code_point[1:0], 4'b0000};
          mode_nxt = MODE_RUN_PEND2;
        end
        default: begin
          merged = left_r | {2'b00, in_data.code_point[15:12]};
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(merged),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[11:6]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          pkt.bytes[n] = '{ch: u7e_pkg::b64_char(in_data.code_point[5:0]),
                           attr: in_data.attribute, forced: 1'b0};
          n = n + 1'b1;
          left_nxt = merged;
          mode_nxt = MODE_RUN_EMPTY;
        end
      endcase
    end
    pkt.count = n;
  end

  // Drop packets with no bytes
  assign q_push = accept && (n != '0);
  assign q_data = pkt;

  // Advance run state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DIRECT;
      left_r <= '0;
      prev_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      prev_r <= prev_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pkt_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_data.count != '0) &&
               (q_data.count <= u7e_pkg::CNT_W'(u7e_pkg::MAX_BYTES)))
    else $error("front pushed a packet with a bad byte count");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == u7e_pkg::OP_END)) |=>
      (mode_r == MODE_DIRECT) && (prev_r == 8'd0))
    else $error("end item did not return the front to direct mode");
`endif

endmodule

[rtl/core/u7e_queue.sv]
// Short packet queue between front and back of the UTF-7 encoder.
// Depends on u7e_pkg.
module u7e_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  u7e_pkg::packet_t  wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output u7e_pkg::packet_t  rd_data,
  output logic              q_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  u7e_pkg::packet_t  slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  assign q_full  = (occ_r == OCC_W'(DEPTH));
  assign q_empty = (occ_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  // Write the slot under the write pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (wr_en && !rd_en) begin
      occ_nxt = occ_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  // Advance pointers with wrap at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && q_full) && !(rd_en && q_empty))
    else $error("queue written while full or read while empty");
`endif

endmodule

[rtl/core/u7e_back.sv]
// Back end: moves head packet bytes one per cycle, unless stalled, to out_r.
// Depends on u7e_pkg.
module u7e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u7e_pkg::packet_t   head,
  input  logic               q_empty,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output u7e_pkg::out_item_t out_data
);

  logic [u7e_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      out_v_r, out_v_nxt;
  u7e_pkg::out_item_t        out_r, out_nxt;
  logic                      load;
  logic                      at_last;
  u7e_pkg::enc_byte_t        cur;

  assign empty    = !out_v_r;
  assign out_data = out_r;
  assign load     = !out_v_r || pop;
  assign cur      = head.bytes[idx_r];
  assign at_last  = (idx_r == head.count - 1'b1);

  // Pick the next byte when the output register frees up
  always_comb begin
    idx_nxt   = idx_r;
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    rd_en     = 1'b0;
    if (load) begin
      out_v_nxt = !q_empty;
      if (!q_empty) begin
        out_nxt = '{out_char: cur.ch, out_attribute: cur.attr,
                    forced: cur.forced, last: at_last};
        if (at_last) begin
          idx_nxt = '0;
          rd_en   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < head.count))
    else $error("byte index ran past the head packet");

  a_idx_home: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (idx_r == '0))
    else $error("byte index not at start while queue is empty");
`endif

endmodule

[rtl/core/utf7_stream_encoder_top.sv]
// Path: an item's first byte goes via a queue slot and the output register to the out ports.
// Throughput: one item per cycle while the packet queue has room; results leave one byte
// per cycle while pop keeps the output free, and an item makes 0 to 5 bytes.
// Reset: synchronous active-low rst_n empties the queue and output and returns to direct mode.
// Top level of the UTF-7 stream encoder: front end, packet queue and back end.
// Depends on u7e_pkg, u7e_front, u7e_queue and u7e_back.
module utf7_stream_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u7e_pkg::in_item_t  in_data,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output u7e_pkg::out_item_t out_data
);

  logic             q_push, q_full, q_rd, q_empty;
  u7e_pkg::packet_t q_wdata, q_head;

  u7e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  u7e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  u7e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .rd_en    (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
